### rtl/core/cmli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - shared types and constants
// Key and colour layouts, field widths, command codes and divider request.
// ----------------------------------------------------------------------------
package cmli_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned RATIO_W = 17;
    localparam int unsigned KC_W    = 6;
    localparam int unsigned FRAC_W  = 17;

    localparam logic [RATIO_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [KC_W-1:0]    KC_RESET  = 6'd2;
    localparam logic [KC_W-1:0]    KC_MIN    = 6'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgba;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_rgba            colour;
    } t_key;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] den;
    } t_div_req;

    localparam t_rgba GREY = '{alpha: 8'hFF, blue: 8'h80, green: 8'h80, red: 8'h80};

endpackage
`default_nettype wire

### rtl/core/cmli_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - channel interfaces
// Command item channel, colour result channel and key count write channel.
// ----------------------------------------------------------------------------
interface cmli_item_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [cmli_pkg::SLOT_W-1:0]      key_slot;
    logic [cmli_pkg::POS_W-1:0]       key_position;
    logic [cmli_pkg::CH_W-1:0]        key_red;
    logic [cmli_pkg::CH_W-1:0]        key_green;
    logic [cmli_pkg::CH_W-1:0]        key_blue;
    logic [cmli_pkg::CH_W-1:0]        key_alpha;
    logic [cmli_pkg::RATIO_W-1:0]     ratio;
    logic                             ratio_undefined;

    modport source (output valid, command, key_slot, key_position, key_red, key_green,
                    key_blue, key_alpha, ratio, ratio_undefined, input ready);
    modport sink   (input valid, command, key_slot, key_position, key_red, key_green,
                    key_blue, key_alpha, ratio, ratio_undefined, output ready);
endinterface

interface cmli_colour_if;
    logic                       valid;
    logic                       ready;
    logic [cmli_pkg::CH_W-1:0]  out_red;
    logic [cmli_pkg::CH_W-1:0]  out_green;
    logic [cmli_pkg::CH_W-1:0]  out_blue;
    logic [cmli_pkg::CH_W-1:0]  out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface cmli_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [cmli_pkg::KC_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/colormap_lookup_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - top level
// Piecewise linear RGBA colour map: key loads, ratio lookups, key count reg.
// ----------------------------------------------------------------------------
//  channel   dir  item
//  i_item    in   load key into slot, or look up colour for a ratio
//  o_item    out  RGBA colour, one per lookup
//  i_cfg     in   key count write
//
//  A load writes the key memory as it is taken. A lookup with an undefined
//  ratio goes straight to the done state; any other lookup scans the key
//  memory one entry per cycle and may then run the fraction divider.
//  Reset sets the key count to 2; key memory contents stay undefined until
//  loaded. A waiting result sits in the output register while the next item
//  is taken; a held result stalls the sequencer only at its final step.
// ----------------------------------------------------------------------------
module colormap_lookup_interpolator #(
    parameter int unsigned MAX_KEYS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cmli_item_if.sink       i_item,
    cmli_colour_if.source   o_item,
    cmli_cfg_if.sink        i_cfg
);
    import cmli_pkg::*;

    logic [KC_W-1:0] r_key_count;
    logic            r_out_valid;
    t_rgba           r_out;
    logic            w_res_valid;
    t_rgba           w_res;
    logic            w_res_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KC_RESET;
        end else if (i_cfg.valid) begin
            r_key_count <= i_cfg.data;
        end
    end

    cmli_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_key_count (r_key_count),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = !r_out_valid || o_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
            if (w_res_valid) begin
                r_out <= w_res;
            end
        end
    end

    assign o_item.valid     = r_out_valid;
    assign o_item.out_red   = r_out.red;
    assign o_item.out_green = r_out.green;
    assign o_item.out_blue  = r_out.blue;
    assign o_item.out_alpha = r_out.alpha;

endmodule
`default_nettype wire

### rtl/core/cmli_key_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - key memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmli_key_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire cmli_pkg::t_key i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output cmli_pkg::t_key      o_rdata
);
    import cmli_pkg::*;

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/cmli_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - fraction divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num < den.
// ----------------------------------------------------------------------------
module cmli_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cmli_pkg::t_div_req         i_req,
    output logic                            o_done,
    output logic [cmli_pkg::POS_W-1:0]      o_quot
);
    import cmli_pkg::*;

    localparam int unsigned CNT_W = $clog2(POS_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W:0]    r_rem;
    logic [POS_W-1:0]  r_den;
    logic [POS_W-1:0]  r_quo;
    logic [POS_W:0]    w_sh;
    logic              w_ge;

    assign w_sh = {r_rem[POS_W-1:0], 1'b0};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_req.num};
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                r_quo <= {r_quo[POS_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

### rtl/core/cmli_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - lookup sequencer
// Loads keys, maps the ratio, scans the key memory, divides and blends.
// ----------------------------------------------------------------------------
module cmli_ctrl #(
    parameter int unsigned MAX_KEYS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    cmli_item_if.sink                     i_item,
    input  wire logic [cmli_pkg::KC_W-1:0] i_key_count,
    output logic                          o_res_valid,
    output cmli_pkg::t_rgba               o_res,
    input  wire logic                     i_res_ready
);
    import cmli_pkg::*;

    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RDF   = 10'b0000000010,
        S_RDL   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_P     = 10'b0000010000,
        S_SCAN  = 10'b0000100000,
        S_FRAC  = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_BLEND = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]      r_raddr;
    logic [AW-1:0]      r_qidx;
    logic [AW-1:0]      r_last;
    logic [RATIO_W-1:0] r_ratio;
    logic [POS_W-1:0]   r_first;
    logic               r_desc;
    logic [POS_W-1:0]   r_sh;
    logic [POS_W-1:0]   r_p;
    t_key               r_prev;
    t_key               r_lo;
    t_key               r_hi;
    logic               r_found;
    logic [FRAC_W-1:0]  r_frac;
    logic [1:0]         r_ch;
    t_rgba              r_res;

    logic               w_acc;
    logic [CW-1:0]      w_n;
    logic [AW-1:0]      w_last;
    logic               w_we;
    t_key               w_wdata;
    t_key               w_q;
    logic [POS_W-1:0]   w_diff;
    logic [RATIO_W+POS_W-1:0] w_prod;
    logic               w_up;
    t_div_req           w_div_req;
    logic               w_div_done;
    logic [POS_W-1:0]   w_quot;
    logic [CH_W-1:0]    w_lo_c;
    logic [CH_W-1:0]    w_hi_c;
    logic signed [CH_W:0]     w_d;
    logic signed [FRAC_W:0]   w_fs;
    logic signed [CH_W+FRAC_W+1:0] w_bp;
    logic [CH_W-1:0]    w_ch;

    assign w_acc = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        if (i_key_count < KC_MIN) begin
            w_n = CW'(KC_MIN);
        end else if (32'(i_key_count) > MAX_KEYS) begin
            w_n = CW'(MAX_KEYS);
        end else begin
            w_n = CW'(i_key_count);
        end
    end
    assign w_last = AW'(w_n - 1'b1);

    assign w_we = w_acc && (i_item.command == CMD_LOAD)
               && (32'(i_item.key_slot) < MAX_KEYS);
    assign w_wdata.pos          = i_item.key_position;
    assign w_wdata.colour.red   = i_item.key_red;
    assign w_wdata.colour.green = i_item.key_green;
    assign w_wdata.colour.blue  = i_item.key_blue;
    assign w_wdata.colour.alpha = i_item.key_alpha;

    cmli_key_ram #(.DEPTH(MAX_KEYS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_item.key_slot)),
        .i_wdata (w_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_q)
    );

    // span from first key to last
    assign w_diff = (w_q.pos >= r_first) ? (w_q.pos - r_first) : (r_first - w_q.pos);
    assign w_prod = r_ratio * w_diff;

    assign w_up = (r_qidx == r_last) || ((r_qidx != '0) && (w_q.pos > r_p));

    assign w_div_req.start = (r_state == S_FRAC) && (r_p > r_lo.pos) && (r_p < r_hi.pos);
    assign w_div_req.num   = r_p - r_lo.pos;
    assign w_div_req.den   = r_hi.pos - r_lo.pos;

    cmli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        unique case (r_ch)
            2'd0: begin w_lo_c = r_lo.colour.red;   w_hi_c = r_hi.colour.red;   end
            2'd1: begin w_lo_c = r_lo.colour.green; w_hi_c = r_hi.colour.green; end
            2'd2: begin w_lo_c = r_lo.colour.blue;  w_hi_c = r_hi.colour.blue;  end
            default: begin w_lo_c = r_lo.colour.alpha; w_hi_c = r_hi.colour.alpha; end
        endcase
    end

    // lo + floor((hi - lo) * frac / 2^16), low byte only
    assign w_d  = $signed({1'b0, w_hi_c}) - $signed({1'b0, w_lo_c});
    assign w_fs = $signed({1'b0, r_frac});
    assign w_bp = w_d * w_fs;
    assign w_ch = w_lo_c + w_bp[CH_W+15:16];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_item.command == CMD_LOOKUP)) begin
                    n_state = i_item.ratio_undefined ? S_DONE : S_RDF;
                end
            end
            S_RDF:  n_state = S_RDL;
            S_RDL:  n_state = S_MUL;
            S_MUL:  n_state = S_P;
            S_P:    n_state = S_SCAN;
            S_SCAN: begin
                if (w_q.pos == r_p) begin
                    n_state = S_DONE;
                end else if (r_qidx == r_last) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: n_state = w_div_req.start ? S_DIV : S_BLEND;
            S_DIV:  n_state = w_div_done ? S_BLEND : S_DIV;
            S_BLEND: n_state = (r_ch == 2'd3) ? S_DONE : S_BLEND;
            S_DONE: n_state = i_res_ready ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_raddr <= '0;
                    r_last  <= w_last;
                    r_ratio <= (i_item.ratio > ONE_Q16) ? ONE_Q16 : i_item.ratio;
                    r_res   <= GREY;
                end
                S_RDF: begin
                    r_raddr <= r_last;
                end
                S_RDL: begin
                    r_first <= w_q.pos;
                end
                S_MUL: begin
                    r_sh    <= w_prod[POS_W+15:16];
                    r_desc  <= (w_q.pos < r_first);
                    r_raddr <= '0;
                end
                S_P: begin
                    r_p     <= r_desc ? (r_first - r_sh) : (r_first + r_sh);
                    r_raddr <= AW'(1);
                    r_qidx  <= '0;
                    r_found <= 1'b0;
                end
                S_SCAN: begin
                    r_res  <= w_q.colour;
                    r_prev <= w_q;
                    r_qidx <= r_qidx + 1'b1;
                    if (r_raddr != r_last) begin
                        r_raddr <= r_raddr + 1'b1;
                    end
                    if (!r_found && w_up) begin
                        r_found <= 1'b1;
                        r_lo    <= r_prev;
                        r_hi    <= w_q;
                    end
                end
                S_FRAC: begin
                    r_frac <= (r_p <= r_lo.pos) ? '0 : ONE_Q16;
                    r_ch   <= '0;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_frac <= {1'b0, w_quot};
                    end
                end
                S_BLEND: begin
                    r_ch <= r_ch + 1'b1;
                    unique case (r_ch)
                        2'd0: r_res.red   <= w_ch;
                        2'd1: r_res.green <= w_ch;
                        2'd2: r_res.blue  <= w_ch;
                        default: r_res.alpha <= w_ch;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
`default_nettype wire

### bench/colormap_lookup_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map lookup interpolator - testbench
// Loads key tables (ascending, duplicated, scrambled, descending span), looks
// up colours for ratios across the span and beyond one, and checks every RGBA
// result against a local model of the key tables and the blend arithmetic.
// Key count is swept through its clamped extremes between quiet phases.
// ----------------------------------------------------------------------------
module colormap_lookup_interpolator_tb;
    import cmli_pkg::*;

    localparam int unsigned KEY_SLOTS   = 32;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE      = 64;

    typedef struct {
        logic               command;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   position;
        t_rgba              colour;
        logic [RATIO_W-1:0] ratio;
        logic               undef;
    } t_map_item;

    logic i_clk;
    logic i_rst_n;

    cmli_item_if   item_ch();
    cmli_colour_if colour_ch();
    cmli_cfg_if    cfg_ch();

    colormap_lookup_interpolator #(
        .MAX_KEYS (KEY_SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_item  (colour_ch),
        .i_cfg   (cfg_ch)
    );

    // local copy of the key tables and the key count
    logic [POS_W-1:0] key_pos_tab  [KEY_SLOTS];
    t_rgba            key_rgba_tab [KEY_SLOTS];
    logic [KC_W-1:0]  key_count_reg;

    t_rgba expected_colours[$];

    int unsigned error_count     = 0;
    int unsigned colours_checked = 0;
    int unsigned loads_sent      = 0;
    int unsigned lookups_sent    = 0;
    int unsigned grey_sent       = 0;
    int unsigned count_writes    = 0;
    int unsigned src_idle_pct    = 26;
    int unsigned rx_stall_pct    = 59;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned active_keys();
        if (key_count_reg < KC_MIN)
            return KC_MIN;
        if (key_count_reg > KEY_SLOTS)
            return KEY_SLOTS;
        return key_count_reg;
    endfunction

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] lo_ch,
                                                    input logic [CH_W-1:0] hi_ch,
                                                    input longint unsigned frac);
        longint unsigned acc;
        acc = (longint'(lo_ch) * (longint'(ONE_Q16) - frac) + longint'(hi_ch) * frac) >> 16;
        return acc[CH_W-1:0];
    endfunction

    function automatic t_rgba map_colour(input logic [RATIO_W-1:0] ratio, input logic undef);
        longint unsigned n, r, first_pos, last_pos, pt, lo_pos, hi_pos, frac;
        int unsigned     up, i;
        logic            hit;
        t_rgba           lo_c, hi_c, res;
        if (undef)
            return GREY;
        n = active_keys();
        r = (ratio > ONE_Q16) ? ONE_Q16 : ratio;
        first_pos = key_pos_tab[0];
        last_pos  = key_pos_tab[n-1];
        if (last_pos >= first_pos)
            pt = first_pos + ((r * (last_pos - first_pos)) >> 16);
        else
            pt = first_pos - ((r * (first_pos - last_pos)) >> 16);
        // exact hit: lowest slot wins
        hit = 1'b0;
        res = GREY;
        for (i = 0; i < n; i++) begin
            if (!hit && key_pos_tab[i] == pt) begin
                hit = 1'b1;
                res = key_rgba_tab[i];
            end
        end
        if (hit)
            return res;
        up = 32'(n - 1);
        for (i = 1; i < n; i++) begin
            if (!hit && key_pos_tab[i] > pt) begin
                hit = 1'b1;
                up  = i;
            end
        end
        lo_pos = key_pos_tab[up-1];
        hi_pos = key_pos_tab[up];
        if (pt <= lo_pos)
            frac = 0;
        else if (pt >= hi_pos)
            frac = ONE_Q16;
        else
            frac = ((pt - lo_pos) << 16) / (hi_pos - lo_pos);
        lo_c = key_rgba_tab[up-1];
        hi_c = key_rgba_tab[up];
        res.red   = mix_channel(lo_c.red,   hi_c.red,   frac);
        res.green = mix_channel(lo_c.green, hi_c.green, frac);
        res.blue  = mix_channel(lo_c.blue,  hi_c.blue,  frac);
        res.alpha = mix_channel(lo_c.alpha, hi_c.alpha, frac);
        return res;
    endfunction

    function automatic t_map_item random_item(input logic cmd);
        t_map_item it;
        it.command  = cmd;
        it.slot     = SLOT_W'($urandom_range(0, KEY_SLOTS - 1));
        it.position = POS_W'($urandom_range(0, 65535));
        it.colour   = t_rgba'($urandom);
        it.ratio    = RATIO_W'($urandom_range(0, 131071));
        it.undef    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_map_item(input t_map_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.command         <= it.command;
        item_ch.key_slot        <= it.slot;
        item_ch.key_position    <= it.position;
        item_ch.key_red         <= it.colour.red;
        item_ch.key_green       <= it.colour.green;
        item_ch.key_blue        <= it.colour.blue;
        item_ch.key_alpha       <= it.colour.alpha;
        item_ch.ratio           <= it.ratio;
        item_ch.ratio_undefined <= it.undef;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        if (it.command == CMD_LOAD) begin
            key_pos_tab[it.slot]  = it.position;
            key_rgba_tab[it.slot] = it.colour;
            loads_sent++;
        end else begin
            expected_colours.push_back(map_colour(it.ratio, it.undef));
            lookups_sent++;
            if (it.undef)
                grey_sent++;
        end
    endtask

    task automatic load_key(input int unsigned slot, input int unsigned pos,
                            input t_rgba colour);
        t_map_item it;
        it          = random_item(CMD_LOAD);
        it.slot     = SLOT_W'(slot);
        it.position = POS_W'(pos);
        it.colour   = colour;
        send_map_item(it);
    endtask

    task automatic look_up(input int unsigned ratio, input logic undef);
        t_map_item it;
        it       = random_item(CMD_LOOKUP);
        it.ratio = RATIO_W'(ratio);
        it.undef = undef;
        send_map_item(it);
    endtask

    // sender holds off until every outstanding colour is back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_colours.size() != 0);
    endtask

    task automatic program_key_count(input logic [KC_W-1:0] value);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid  <= 1'b0;
        key_count_reg  = value;
        count_writes++;
    endtask

    task automatic test_grey_and_span();
        look_up($urandom_range(0, 131071), 1'b1);
        load_key(0, 16'h0000, t_rgba'(32'h0000_0000));
        load_key(1, 16'hFFFF, t_rgba'(32'hFFFF_FFFF));
        look_up(0, 1'b0);
        look_up(ONE_Q16, 1'b0);
        look_up(17'h0_8000, 1'b0);
        look_up(17'h1_FFFF, 1'b0);
        look_up(17'h1_0001, 1'b0);
        look_up(1, 1'b0);
        look_up(17'h0_FFFF, 1'b0);
        look_up(17'h1_FFFF, 1'b1);
        drain_results();
    endtask

    // duplicate positions, a key out of order, and a last key below the first
    task automatic test_irregular_keys();
        program_key_count(5);
        load_key(0, 1000, t_rgba'(32'h11_22_33_44));
        load_key(1, 1000, t_rgba'(32'hEE_DD_CC_BB));
        load_key(2, 3000, t_rgba'(32'h80_40_20_10));
        load_key(3, 2000, t_rgba'(32'h01_F0_7F_FE));
        load_key(4, 500,  t_rgba'(32'hFF_00_FF_00));
        look_up(0, 1'b0);
        look_up(ONE_Q16, 1'b0);
        look_up(17'h0_8000, 1'b0);
        look_up(17'h0_4000, 1'b0);
        look_up(17'h0_F000, 1'b0);
        look_up(17'h0_8000, 1'b1);
    endtask

    task automatic test_random_maps();
        int unsigned     ph, n, s, k, lookups, roll, step, nxt;
        logic [KC_W-1:0] kc;
        logic [POS_W-1:0] pos;
        logic            scrambled, narrow;
        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: kc = 2;
                1: kc = 32;
                2: kc = 1;
                3: kc = 6;
                4: kc = 63;
                5: kc = 0;
                6: kc = 12;
                7: kc = 33;
                default: kc = 4;
            endcase
            if (ph == 3) begin
                src_idle_pct = 59;
                rx_stall_pct = 26;
            end else if (ph == 6) begin
                src_idle_pct = 0;
                rx_stall_pct = 0;
            end
            program_key_count(kc);
            n         = 32'(active_keys());
            scrambled = ($urandom_range(0, 3) == 0);
            narrow    = ($urandom_range(0, 2) == 0);
            step      = narrow ? 3 : (131070 / n);
            pos       = POS_W'($urandom_range(0, narrow ? 65000 : 2000));
            for (s = 0; s < n; s++) begin
                if (scrambled) begin
                    load_key(s, $urandom_range(0, 65535), t_rgba'($urandom));
                end else begin
                    load_key(s, pos, t_rgba'($urandom));
                    nxt = pos + $urandom_range(0, step);
                    pos = (nxt > 65535) ? 16'hFFFF : nxt[POS_W-1:0];
                end
            end
            lookups = (n + 20 < 50) ? 50 - n : 20;
            for (k = 0; k < lookups; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    look_up($urandom_range(0, 131071), 1'b1);
                else if (roll < 13)
                    load_key($urandom_range(0, KEY_SLOTS - 1), $urandom_range(0, 65535),
                             t_rgba'($urandom));
                else if (roll < 16)
                    look_up(roll[0] ? 0 : ONE_Q16, 1'b0);
                else if (roll < 19)
                    look_up($urandom_range(65537, 131071), 1'b0);
                else
                    look_up($urandom_range(0, 65536), 1'b0);
            end
        end
    endtask

    function automatic void check_channel(input string name, input logic [CH_W-1:0] want,
                                          input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n === 1'b1 && colour_ch.valid === 1'b1 && colour_ch.ready === 1'b1) begin
            if (expected_colours.size() == 0) begin
                $error("colour item with no lookup outstanding");
                error_count++;
            end else begin
                want = expected_colours.pop_front();
                check_channel("out_red",   want.red,   colour_ch.out_red);
                check_channel("out_green", want.green, colour_ch.out_green);
                check_channel("out_blue",  want.blue,  colour_ch.out_blue);
                check_channel("out_alpha", want.alpha, colour_ch.out_alpha);
                colours_checked++;
            end
        end
        colour_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (colour_ch.valid === 1'b1 && colour_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("colormap_lookup_interpolator_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n                 <= 1'b0;
        item_ch.valid           <= 1'b0;
        item_ch.command         <= CMD_LOAD;
        item_ch.key_slot        <= '0;
        item_ch.key_position    <= '0;
        item_ch.key_red         <= '0;
        item_ch.key_green       <= '0;
        item_ch.key_blue        <= '0;
        item_ch.key_alpha       <= '0;
        item_ch.ratio           <= '0;
        item_ch.ratio_undefined <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.data             <= '0;
        key_count_reg            = KC_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grey_and_span();
        test_irregular_keys();
        test_random_maps();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_colours.size() != 0) begin
            $error("%0d colours never arrived", expected_colours.size());
            error_count++;
        end
        $display("covered %0d key loads and %0d lookups (%0d with undefined ratio)",
                 loads_sent, lookups_sent, grey_sent);
        $display("over %0d key count settings; %0d colours compared, %0d mismatches",
                 count_writes, colours_checked, error_count);
        if (error_count == 0)
            $display("colormap_lookup_interpolator_tb: done, clean");
        else
            $display("colormap_lookup_interpolator_tb: done, errors");
        $finish;
    end

endmodule
